// ===== sv/qst_pkg.sv =====
// Package for the quadratic servo trajectory block.
// Holds field widths, mode and term codes, register indexes and parameter defaults.
// No dependencies.
package qst_pkg;

  localparam int unsigned SERVO_COUNT_DEF = 4;
  localparam int unsigned COEFF_SHIFT_DEF = 8;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned LEVEL_W  = 10;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned SERVO_W  = 4;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned TERM_W   = 2;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned NUM_TERMS = 3;
  localparam int unsigned BIT_W    = $clog2(DATA_W);

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  localparam logic [TERM_W-1:0] TERM_C0 = 2'd0;
  localparam logic [TERM_W-1:0] TERM_C1 = 2'd1;
  localparam logic [TERM_W-1:0] TERM_C2 = 2'd2;

  localparam logic REG_TICK_LIMIT  = 1'b0;
  localparam logic REG_TOUCH_LIMIT = 1'b1;

  localparam logic [LEVEL_W-1:0] TOUCH_LIMIT_RST = 10'h3FF;

endpackage

// ===== sv/quadratic_servo_trajectory.sv =====
// Quadratic servo trajectory generator: top level with control, APB registers and datapath.
// Depends on qst_pkg and qst_ram (one coefficient RAM per polynomial term).
//
// A start or coefficient-write transaction is handled without leaving the idle state. A
// tick while moving emits one position per servo; each servo goes through a coefficient
// read, an operand load, 32 steps of a bit-serial shift-add multiplier that forms
// c2*t*t + c1*t one multiplier bit per cycle, and an output step that waits out any
// output stall. A tick that ends the movement emits one finished result. The next input
// transaction is taken once the tick is fully issued; the last result may still sit in
// the output register. Coefficients read as zero until written; no clearing pass is
// needed after reset.
module quadratic_servo_trajectory
  import qst_pkg::*;
#(
  parameter int unsigned SERVO_COUNT = SERVO_COUNT_DEF,
  parameter int unsigned COEFF_SHIFT = COEFF_SHIFT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic [SERVO_W-1:0]       servo_index_i,
  input  logic [TERM_W-1:0]        coeff_term_i,
  input  logic signed [DATA_W-1:0] coeff_value_i,
  input  logic [LEVEL_W-1:0]       touch_level_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SERVO_W-1:0]       servo_number_o,
  output logic [POS_W-1:0]         position_o,
  output logic [TICK_W-1:0]        tick_index_o,
  output logic                     finished_o,
  output logic                     last_o
);

  localparam int unsigned ADDR_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic                        moving_q;
  logic [TICK_W-1:0]           tick_q;
  logic [DATA_W-1:0]           tsq_q;
  logic [SERVO_W-1:0]          k_q;
  logic [BIT_W-1:0]            bit_q;
  logic                        out_valid_q;
  logic [TICK_W-1:0]           tick_limit_q;
  logic [LEVEL_W-1:0]          touch_limit_q;
  logic [SERVO_COUNT-1:0]      vld_q [NUM_TERMS];
  logic [NUM_TERMS-1:0]        rd_vld_q;

  logic [DATA_W-1:0]           a2_q, a1_q, m2_q, acc_q;
  logic [TICK_W-1:0]           m1_q;
  logic [POS_W-1:0]            c0_q;

  logic [SERVO_W-1:0]          servo_number_q;
  logic [POS_W-1:0]            position_q;
  logic [TICK_W-1:0]           tick_index_q;
  logic                        finished_q;
  logic                        last_q;

  logic                        in_acc, go, out_free, last_servo, mul_end;
  logic                        cfg_we, wr_coeff;
  logic                        emit_load, done_load;
  logic [NUM_TERMS-1:0]        ram_we;
  logic [DATA_W-1:0]           ram_rdata [NUM_TERMS];
  logic [DATA_W-1:0]           coef [NUM_TERMS];
  logic [ADDR_W-1:0]           waddr, raddr;
  logic [DATA_W-1:0]           acc_sum;
  logic signed [DATA_W-1:0]    acc_sra;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TICK_LIMIT)
                ? {{(DATA_W-TICK_W){1'b0}}, tick_limit_q}
                : {{(DATA_W-LEVEL_W){1'b0}}, touch_limit_q};

  // Handshake and decode
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign go         = (touch_level_i < touch_limit_q) && (tick_q < tick_limit_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_servo = (k_q == SERVO_W'(SERVO_COUNT - 1));
  assign mul_end    = (bit_q == BIT_W'(DATA_W - 1));
  assign emit_load  = (state_q == ST_EMIT) && out_free;
  assign done_load  = (state_q == ST_DONE) && out_free;
  assign wr_coeff   = in_acc && (mode_i == MODE_WRITE)
                   && ({1'b0, servo_index_i} < (SERVO_W + 1)'(SERVO_COUNT))
                   && (coeff_term_i inside {TERM_C0, TERM_C1, TERM_C2});
  assign waddr      = servo_index_i[ADDR_W-1:0];
  assign raddr      = k_q[ADDR_W-1:0];

  // Coefficient RAMs, one per term
  for (genvar g = 0; g < NUM_TERMS; g++) begin : g_term
    assign ram_we[g] = wr_coeff && (coeff_term_i == TERM_W'(g));
    assign coef[g]   = ram_rdata[g] & {DATA_W{rd_vld_q[g]}};

    qst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SERVO_COUNT)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .waddr_i (waddr),
      .wdata_i ($unsigned(coeff_value_i)),
      .raddr_i (raddr),
      .rdata_o (ram_rdata[g])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= '0;
      end else if (ram_we[g]) begin
        vld_q[g][waddr] <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      rd_vld_q[g] <= vld_q[g][raddr];
    end
  end

  // Shift-add step and final scaling
  assign acc_sum = acc_q + (m2_q[0] ? a2_q : '0) + (m1_q[0] ? a1_q : '0);
  assign acc_sra = $signed(acc_q) >>> COEFF_SHIFT;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (mode_i == MODE_TICK) && moving_q) begin
          state_d = go ? ST_READ : ST_DONE;
        end
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_MUL;
      ST_MUL: begin
        if (mul_end) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = last_servo ? ST_IDLE : ST_READ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      moving_q      <= 1'b0;
      tick_q        <= '0;
      tsq_q         <= '0;
      k_q           <= '0;
      bit_q         <= '0;
      out_valid_q   <= 1'b0;
      tick_limit_q  <= '0;
      touch_limit_q <= TOUCH_LIMIT_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= emit_load || done_load || (out_valid_q && !out_ready_i);
      if (cfg_we) begin
        if (paddr[2] == REG_TICK_LIMIT) begin
          tick_limit_q <= pwdata[TICK_W-1:0];
        end else begin
          touch_limit_q <= pwdata[LEVEL_W-1:0];
        end
      end
      if (in_acc && (mode_i == MODE_START)) begin
        tick_q   <= '0;
        tsq_q    <= '0;
        moving_q <= 1'b1;
      end
      if (in_acc && (mode_i == MODE_TICK)) begin
        k_q <= '0;
        if (moving_q && !go) begin
          moving_q <= 1'b0;
        end
      end
      if (state_q == ST_MUL) begin
        bit_q <= bit_q + 1'b1;
      end
      if (emit_load) begin
        if (last_servo) begin
          tick_q <= tick_q + 1'b1;
          tsq_q  <= tsq_q + {{(DATA_W-TICK_W-1){1'b0}}, tick_q, 1'b1};
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      a2_q  <= coef[TERM_C2];
      a1_q  <= coef[TERM_C1];
      c0_q  <= coef[TERM_C0][POS_W-1:0];
      m2_q  <= tsq_q;
      m1_q  <= tick_q;
      acc_q <= '0;
    end else if (state_q == ST_MUL) begin
      acc_q <= acc_sum;
      a2_q  <= a2_q << 1;
      a1_q  <= a1_q << 1;
      m2_q  <= m2_q >> 1;
      m1_q  <= m1_q >> 1;
    end
    if (emit_load) begin
      servo_number_q <= k_q;
      position_q     <= acc_sra[POS_W-1:0] + c0_q;
      tick_index_q   <= tick_q;
      finished_q     <= 1'b0;
      last_q         <= last_servo;
    end else if (done_load) begin
      servo_number_q <= '0;
      position_q     <= '0;
      tick_index_q   <= tick_q;
      finished_q     <= 1'b1;
      last_q         <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign servo_number_o = servo_number_q;
  assign position_o     = position_q;
  assign tick_index_o   = tick_index_q;
  assign finished_o     = finished_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_square_tracks_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tsq_q == DATA_W'({{(DATA_W-TICK_W){1'b0}}, tick_q} * {{(DATA_W-TICK_W){1'b0}}, tick_q}))
    else $error("tick square out of step with tick counter");

  a_finished_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> (last_o && (position_o == '0) && (servo_number_o == '0)))
    else $error("finished result malformed");

  a_stop_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !moving_q)
    else $error("moving flag still set while ending movement");

  a_servo_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= SERVO_W'(SERVO_COUNT - 1))
    else $error("servo counter beyond servo count");
`endif

endmodule

// ===== sv/qst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
